// ===== rtl/core/cmv_pkg.sv =====
// ----------------------------------------------------------------------------
// cmv_pkg: shared types and codes for the column majority vote decoder
// Request codes, the command word that flows from front to back, and the
// fixed field widths of the channels.
// ----------------------------------------------------------------------------
package cmv_pkg;

  localparam int COLUMN_W = 4;
  localparam int LETTER_W = 5;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 5'd8;

  // Request codes on req_type
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REPORT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Command word handed from the front to the back through the queue
  typedef struct packed {
    logic [1:0]          op;
    logic [COLUMN_W-1:0] column;
    logic [LETTER_W-1:0] letter;
  } cmd_t;

endpackage

// ===== rtl/core/cmv_if.sv =====
// ----------------------------------------------------------------------------
// cmv_if: valid/ready channels of the column majority vote decoder
// Request, result and configuration channels, each with source and sink
// modports.
// ----------------------------------------------------------------------------
interface cmv_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [3:0] column;
  logic [4:0] letter;

  modport source (output valid, output req_type, output column, output letter,
                  input ready);
  modport sink   (input valid, input req_type, input column, input letter,
                  output ready);
endinterface

interface cmv_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_column;
  logic [4:0] most_letter;
  logic [4:0] least_letter;
  logic       last;

  modport source (output valid, output out_column, output most_letter,
                  output least_letter, output last, input ready);
  modport sink   (input valid, input out_column, input most_letter,
                  input least_letter, input last, output ready);
endinterface

interface cmv_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] column_count;

  modport source (output valid, output column_count, input ready);
  modport sink   (input valid, input column_count, output ready);
endinterface

// ===== rtl/core/cmv_front.sv =====
// ----------------------------------------------------------------------------
// cmv_front: request intake and classification
// Accepts request words, drops unused codes and out-of-range adds, and
// pushes the rest as commands into the queue.
// ----------------------------------------------------------------------------
module cmv_front #(
  parameter int MAX_COLUMNS   = 16,
  parameter int ALPHABET_SIZE = 26
) (
  cmv_req_if.sink       req,
  input  logic          q_full,
  input  logic          init_busy,
  output logic          push,
  output cmv_pkg::cmd_t push_cmd
);
  import cmv_pkg::*;

  logic        accept;
  logic        keep;
  logic        col_ok;
  logic        let_ok;
  logic [31:0] col_wide;
  logic [31:0] let_wide;

  // Hold off while the queue is full or the store is being cleared after reset
  assign req.ready = !q_full && !init_busy;
  assign accept    = req.valid && req.ready;

  // Range checks for add words
  assign col_wide = 32'(req.column);
  assign let_wide = 32'(req.letter);
  assign col_ok   = col_wide < MAX_COLUMNS;
  assign let_ok   = let_wide < ALPHABET_SIZE;

  // Classify: keep report, clear and in-range add words
  always_comb begin
    case (req.req_type)
      REQ_ADD:    keep = col_ok && let_ok;
      REQ_REPORT: keep = 1'b1;
      REQ_CLEAR:  keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  assign push            = accept && keep;
  assign push_cmd.op     = req.req_type;
  assign push_cmd.column = req.column;
  assign push_cmd.letter = req.letter;

endmodule

// ===== rtl/core/cmv_queue.sv =====
// ----------------------------------------------------------------------------
// cmv_queue: two-entry command queue
// Decouples the request front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module cmv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmv_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output cmv_pkg::cmd_t pop_cmd,
  output logic          not_empty
);
  import cmv_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_cmd   = entries[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/cmv_back.sv =====
// ----------------------------------------------------------------------------
// cmv_back: counter store and command execution
// Holds the letter histogram memory, runs add read-modify-writes, clearing
// sweeps and per-column min/max scans, and drives the result register.
// ----------------------------------------------------------------------------
module cmv_back #(
  parameter int MAX_COLUMNS   = 16,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  cmv_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  logic [4:0]    column_count,
  output logic          init_busy,
  cmv_rsp_if.source     rsp
);
  import cmv_pkg::*;

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LW    = $clog2(ALPHABET_SIZE);
  localparam int AW    = CW + LW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(MAX_COLUMNS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [2:0]             state;
  logic [AW-1:0]          clr_addr;
  logic [AW-1:0]          add_addr;
  logic [CW-1:0]          scan_col;
  logic [LW-1:0]          scan_idx;
  logic                   d_valid;
  logic [LW-1:0]          d_idx;
  logic [COUNT_WIDTH-1:0] hi;
  logic [COUNT_WIDTH-1:0] lo;
  logic [LW-1:0]          hi_idx;
  logic [LW-1:0]          lo_idx;
  logic [NW-1:0]          n_cols;
  logic                   out_valid;
  logic [3:0]             res_column;
  logic [4:0]             res_most;
  logic [4:0]             res_least;
  logic                   res_last;

  logic [31:0]            cc_wide;
  logic [31:0]            n_lim;
  logic [31:0]            cmd_col_wide;
  logic [31:0]            cmd_let_wide;
  logic [AW-1:0]          cmd_addr;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic                   scan_end;
  logic                   last_col;
  logic                   emit_ok;
  logic [31:0]            col_wide;
  logic [31:0]            hi_wide;
  logic [31:0]            lo_wide;

  // Saturate the column count to the store size
  assign cc_wide = 32'(column_count);
  assign n_lim   = (cc_wide > MAX_COLUMNS) ? 32'(MAX_COLUMNS) : cc_wide;

  // Counter address of an add word
  assign cmd_col_wide = 32'(cmd.column);
  assign cmd_let_wide = 32'(cmd.letter);
  assign cmd_addr     = {cmd_col_wide[CW-1:0], cmd_let_wide[LW-1:0]};

  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign rd_addr = (state == ST_IDLE) ? cmd_addr : {scan_col, scan_idx};

  // Write port: zero during a sweep, bump a counter below its ceiling on add
  assign mem_we    = (state == ST_CLEAR) || ((state == ST_ADD) && !(&rd_data));
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : add_addr;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : rd_data + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign scan_end = (32'(scan_idx) == ALPHABET_SIZE - 1);
  assign col_wide = 32'(scan_col);
  assign last_col = (col_wide + 32'd1 == 32'(n_cols));
  assign emit_ok  = !out_valid || rsp.ready;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      init_busy <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              REQ_ADD: begin
                add_addr <= cmd_addr;
                state    <= ST_ADD;
              end
              REQ_CLEAR: begin
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              REQ_REPORT: begin
                n_cols   <= n_lim[NW-1:0];
                scan_col <= '0;
                scan_idx <= '0;
                state    <= (n_lim == 32'd0) ? ST_IDLE : ST_SCAN;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_ADD: begin
          state <= ST_IDLE;
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) begin
            init_busy <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + LW'(1);
          if (scan_end) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            if (last_col) begin
              state <= ST_IDLE;
            end else begin
              scan_col <= scan_col + CW'(1);
              scan_idx <= '0;
              state    <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Track largest and smallest count of the column, first index wins ties
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= (state == ST_SCAN);
    end
    d_idx <= scan_idx;
    if (d_valid) begin
      if (d_idx == '0) begin
        hi     <= rd_data;
        lo     <= rd_data;
        hi_idx <= '0;
        lo_idx <= '0;
      end else begin
        if (rd_data > hi) begin
          hi     <= rd_data;
          hi_idx <= d_idx;
        end
        if (rd_data < lo) begin
          lo     <= rd_data;
          lo_idx <= d_idx;
        end
      end
    end
  end

  assign hi_wide = 32'(hi_idx);
  assign lo_wide = 32'(lo_idx);

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && emit_ok) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && emit_ok) begin
      res_column <= col_wide[3:0];
      res_most   <= hi_wide[4:0];
      res_least  <= lo_wide[4:0];
      res_last   <= last_col;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_column   = res_column;
  assign rsp.most_letter  = res_most;
  assign rsp.least_letter = res_least;
  assign rsp.last         = res_last;

endmodule

// ===== rtl/core/column_majority_vote_decoder_unit.sv =====
// Add: the counter is read when the word leaves the queue and is written back
// from ST_ADD; no further command is popped until that RMW is done.
// Report: one counter read per cycle from the single read port while a column
// is scanned; each result waits in ST_EMIT for the result register. Clear: a
// sweep zeroes every counter. Reset: synchronous; column_count returns to 8
// and a sweep of all 2^(CW+LW) counters (512 by default) runs before a request is taken.
// ----------------------------------------------------------------------------
// column_majority_vote_decoder_unit: per-column letter histogram decoder
// Counts letters per column and reports the most and least frequent letter
// of every column in use.
// ----------------------------------------------------------------------------
module column_majority_vote_decoder_unit #(
  parameter int MAX_COLUMNS   = 16,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_WIDTH   = 16
) (
  input logic       clk,
  input logic       rst,
  cmv_req_if.sink   req,
  cmv_rsp_if.source rsp,
  cmv_cfg_if.sink   cfg
);
  import cmv_pkg::*;

  logic             column_count_q;
  logic [CFG_W-1:0] column_count;
  logic             q_push;
  cmd_t             q_push_cmd;
  logic             q_full;
  logic             q_pop;
  cmd_t             q_pop_cmd;
  logic             q_valid;
  logic             init_busy;

  // Configuration register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= COLUMN_COUNT_RESET;
      column_count_q <= 1'b0;
    end else begin
      column_count_q <= cfg.valid;
      if (cfg.valid) begin
        column_count <= cfg.column_count;
      end
    end
  end

  cmv_front #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .req      (req),
    .q_full   (q_full),
    .init_busy(init_busy),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  cmv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .not_empty(q_valid)
  );

  cmv_back #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (q_pop_cmd),
    .cmd_valid   (q_valid),
    .cmd_pop     (q_pop),
    .column_count(column_count),
    .init_busy   (init_busy),
    .rsp         (rsp)
  );

  // Never push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  // Never pop an empty queue
  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // Stay quiet on both channels during the post-reset sweep
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (!rsp.valid && !req.ready))
    else $error("traffic during post-reset clearing sweep");

  // A configuration write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> (column_count_q && column_count == $past(cfg.column_count)))
    else $error("column_count write lost");

endmodule
